// ===== hdl/paired_sample_frame_autorange_macros.svh =====
// assertion macros for the paired sample frame autorange block
`ifndef PAIRED_SAMPLE_FRAME_AUTORANGE_MACROS_SVH
`define PAIRED_SAMPLE_FRAME_AUTORANGE_MACROS_SVH

// condition implies expression in the same cycle
`define PSFA_ASSERT_SAME(label, clk, rst_n, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
		else $error(msg);

// condition implies expression in the next cycle
`define PSFA_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
		else $error(msg);

`endif

// ===== hdl/psfa_pkg.sv =====
// shared types, constants and codes for the paired sample frame autorange block
package psfa_pkg;

	localparam int PAIRS_PER_FRAME = 15;

	localparam int ADC_W      = 12;
	localparam int SWITCH_W   = 2;
	localparam int SUM_W      = 16;
	localparam int DIFF_W     = 17;
	localparam int GAIN_W     = 2;
	localparam int DUTY_W     = 16;
	localparam int LIMIT_W    = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam int ADC_MAX    = 2047;
	localparam int FULL_SCALE = PAIRS_PER_FRAME * ADC_MAX;
	localparam int LEVEL_W    = $clog2(FULL_SCALE + 1);
	localparam int PAIR_W     = $clog2(PAIRS_PER_FRAME + 1);

	localparam logic signed [DIFF_W-1:0] FULL_SCALE_S = DIFF_W'(FULL_SCALE);
	localparam logic [PAIR_W-1:0] LAST_PAIR = PAIR_W'(PAIRS_PER_FRAME - 1);

	// duty = floor((level * DUTY_MAX + FULL_SCALE / 2) / FULL_SCALE) by reciprocal,
	// shift chosen so that 2^shift > FULL_SCALE * (FULL_SCALE + 1) keeps it exact
	localparam longint unsigned DUTY_MAX   = 65535;
	localparam int              DUTY_SHIFT = $clog2(longint'(FULL_SCALE) * (FULL_SCALE + 1) + 1);
	localparam longint unsigned DUTY_MULT  =
		((DUTY_MAX << DUTY_SHIFT) + longint'(FULL_SCALE) - 1) / longint'(FULL_SCALE);
	localparam longint unsigned DUTY_ROUND =
		((longint'(FULL_SCALE / 2) << DUTY_SHIFT) + longint'(FULL_SCALE) - 1)
		/ longint'(FULL_SCALE);
	localparam int MULT_W = $clog2(DUTY_MULT + 1);
	localparam int PROD_W = LEVEL_W + MULT_W + 1;

	// gain codes and the switch code for autoranging
	localparam logic [GAIN_W-1:0]   GAIN_MIN    = 2'd0;
	localparam logic [GAIN_W-1:0]   GAIN_MED    = 2'd1;
	localparam logic [GAIN_W-1:0]   GAIN_MAX    = 2'd2;
	localparam logic [SWITCH_W-1:0] SWITCH_AUTO = 2'd3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_RAISE_LIMIT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LOWER_LIMIT = 1'd1;

	localparam logic [LIMIT_W-1:0] RAISE_LIMIT_RESET = 16'd3840;
	localparam logic [LIMIT_W-1:0] LOWER_LIMIT_RESET = 16'd26880;

	// stream packing
	localparam int IN_FIELDS_W  = ADC_W + SWITCH_W;
	localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_FIELDS_W = 2 * SUM_W + DIFF_W + 2 * GAIN_W + 1 + DUTY_W;
	localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

	typedef struct packed {
		logic [LIMIT_W-1:0] raise_limit;
		logic [LIMIT_W-1:0] lower_limit;
	} limits_t;

	typedef struct packed {
		logic signed [SUM_W-1:0]  baseline_sum;
		logic signed [SUM_W-1:0]  signal_sum;
		logic signed [DIFF_W-1:0] difference_sum;
		logic [LEVEL_W-1:0]       level;
		logic [SWITCH_W-1:0]      switches;
	} frame_t;

	typedef struct packed {
		logic signed [SUM_W-1:0]  baseline_sum;
		logic signed [SUM_W-1:0]  signal_sum;
		logic signed [DIFF_W-1:0] difference_sum;
		logic [GAIN_W-1:0]        frame_gain;
		logic                     auto_mode;
		logic [GAIN_W-1:0]        next_gain;
		logic [DUTY_W-1:0]        pwm_duty;
	} result_t;

endpackage

// ===== hdl/psfa_accum.sv =====
// pairing of readings and frame accumulation, frame register stage
module psfa_accum import psfa_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [ADC_W-1:0]  adc_sample,
	input  logic [SWITCH_W-1:0]      gain_switches,
	output logic                     frame_valid,
	output frame_t                   frame,
	input  logic                     frame_take
);

	logic                     expect_baseline_q;
	logic signed [ADC_W-1:0]  held_baseline_q;
	logic [PAIR_W-1:0]        pair_count_q;
	logic signed [SUM_W-1:0]  acc_baseline_q;
	logic signed [SUM_W-1:0]  acc_signal_q;
	logic signed [DIFF_W-1:0] acc_difference_q;
	logic                     frame_valid_s1;
	frame_t                   frame_s1;

	logic                     accept;
	logic                     frame_end;
	logic signed [ADC_W:0]    pair_diff;
	logic signed [SUM_W-1:0]  baseline_next;
	logic signed [SUM_W-1:0]  signal_next;
	logic signed [DIFF_W-1:0] difference_next;
	logic [LEVEL_W-1:0]       level;

	assign in_ready  = !frame_valid_s1 || frame_take;
	assign accept    = in_valid && in_ready;
	assign frame_end = !expect_baseline_q && (pair_count_q == LAST_PAIR);

	always_comb begin
		pair_diff = {adc_sample[ADC_W-1], adc_sample}
			- {held_baseline_q[ADC_W-1], held_baseline_q};
		baseline_next = acc_baseline_q
			+ {{(SUM_W-ADC_W){held_baseline_q[ADC_W-1]}}, held_baseline_q};
		signal_next = acc_signal_q
			+ {{(SUM_W-ADC_W){adc_sample[ADC_W-1]}}, adc_sample};
		difference_next = acc_difference_q
			+ {{(DIFF_W-ADC_W-1){pair_diff[ADC_W]}}, pair_diff};
		// clamp to 0..full scale for duty and autorange
		if (difference_next[DIFF_W-1] || difference_next == '0) begin
			level = '0;
		end else if (difference_next > FULL_SCALE_S) begin
			level = LEVEL_W'(FULL_SCALE);
		end else begin
			level = difference_next[LEVEL_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expect_baseline_q <= 1'b0;
			held_baseline_q   <= '0;
			pair_count_q      <= '0;
			acc_baseline_q    <= '0;
			acc_signal_q      <= '0;
			acc_difference_q  <= '0;
		end else if (accept) begin
			if (expect_baseline_q) begin
				held_baseline_q   <= adc_sample;
				expect_baseline_q <= 1'b0;
			end else begin
				expect_baseline_q <= 1'b1;
				if (frame_end) begin
					pair_count_q     <= '0;
					acc_baseline_q   <= '0;
					acc_signal_q     <= '0;
					acc_difference_q <= '0;
				end else begin
					pair_count_q     <= pair_count_q + 1'b1;
					acc_baseline_q   <= baseline_next;
					acc_signal_q     <= signal_next;
					acc_difference_q <= difference_next;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_valid_s1 <= 1'b0;
		end else if (accept && frame_end) begin
			frame_valid_s1 <= 1'b1;
		end else if (frame_take) begin
			frame_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && frame_end) begin
			frame_s1.baseline_sum   <= baseline_next;
			frame_s1.signal_sum     <= signal_next;
			frame_s1.difference_sum <= difference_next;
			frame_s1.level          <= level;
			frame_s1.switches       <= gain_switches;
		end
	end

	assign frame_valid = frame_valid_s1;
	assign frame       = frame_s1;

endmodule

// ===== hdl/psfa_scale.sv =====
// gain selection, duty scaling and result register
module psfa_scale import psfa_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    frame_valid,
	input  frame_t  frame,
	output logic    frame_take,
	input  limits_t limits,
	output logic    res_valid,
	input  logic    res_ready,
	output result_t res
);

	logic [GAIN_W-1:0] current_gain_q;
	logic              res_valid_q;
	result_t           res_q;

	logic              is_auto;
	logic [GAIN_W-1:0] auto_gain;
	logic [GAIN_W-1:0] next_gain;
	logic [PROD_W-1:0] duty_prod;

	assign frame_take = frame_valid && (!res_valid_q || res_ready);
	assign is_auto    = (frame.switches == SWITCH_AUTO);

	always_comb begin
		// hysteresis between the two limits
		if (LIMIT_W'(frame.level) > limits.lower_limit) begin
			auto_gain = (current_gain_q == GAIN_MAX) ? GAIN_MED : GAIN_MIN;
		end else if (LIMIT_W'(frame.level) < limits.raise_limit) begin
			auto_gain = (current_gain_q == GAIN_MIN) ? GAIN_MED : GAIN_MAX;
		end else begin
			auto_gain = current_gain_q;
		end
		next_gain = is_auto ? auto_gain : GAIN_W'(frame.switches);
		duty_prod = PROD_W'(frame.level) * PROD_W'(DUTY_MULT) + PROD_W'(DUTY_ROUND);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			current_gain_q <= GAIN_MED;
			res_valid_q    <= 1'b0;
		end else begin
			if (frame_take) begin
				current_gain_q <= next_gain;
				res_valid_q    <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (frame_take) begin
			res_q.baseline_sum   <= frame.baseline_sum;
			res_q.signal_sum     <= frame.signal_sum;
			res_q.difference_sum <= frame.difference_sum;
			res_q.frame_gain     <= current_gain_q;
			res_q.auto_mode      <= is_auto;
			res_q.next_gain      <= next_gain;
			res_q.pwm_duty       <= duty_prod[DUTY_SHIFT +: DUTY_W];
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// ===== hdl/paired_sample_frame_autorange.sv =====
// Paired sample frame accumulator with gain autoranging. Readings alternate baseline and
// signal, starting after reset with a signal reading paired against a zero baseline. Each
// frame of PAIRS_PER_FRAME pairs yields one output transaction with the baseline, signal and
// difference sums, the gain in force, the mode, the gain for the next frame and a PWM duty
// rounded from the difference sum clamped to 0..full scale. The block accepts one reading
// per clock as long as the output side keeps up; a finished frame that waits behind a held
// result holds s_tready low. The edge that accepts the last reading of a frame loads the
// frame register, and the result register loads from it through the scaling stage with its
// 15 x 32 bit constant multiplier when no result is held or it is taken, raising m_tvalid.
// Limit registers are to be written by the user via the cfg port only while idle, unchecked.
`include "paired_sample_frame_autorange_macros.svh"

module paired_sample_frame_autorange import psfa_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// adc_sample [11:0], gain_switches [13:12], zero pad
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// baseline_sum [15:0], signal_sum [31:16], difference_sum [48:32], frame_gain [50:49],
	// auto_mode [51], next_gain [53:52], pwm_duty [69:54], zero pad
	output logic [OUT_TDATA_W-1:0] m_tdata,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	limits_t limits_q;
	logic    frame_valid;
	frame_t  frame;
	logic    frame_take;
	result_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limits_q.raise_limit <= RAISE_LIMIT_RESET;
			limits_q.lower_limit <= LOWER_LIMIT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_RAISE_LIMIT: limits_q.raise_limit <= cfg_data[LIMIT_W-1:0];
				CFG_LOWER_LIMIT: limits_q.lower_limit <= cfg_data[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	psfa_accum u_accum (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_tvalid),
		.in_ready      (s_tready),
		.adc_sample    (s_tdata[ADC_W-1:0]),
		.gain_switches (s_tdata[ADC_W +: SWITCH_W]),
		.frame_valid   (frame_valid),
		.frame         (frame),
		.frame_take    (frame_take)
	);

	psfa_scale u_scale (
		.clk         (clk),
		.arst_n      (arst_n),
		.frame_valid (frame_valid),
		.frame       (frame),
		.frame_take  (frame_take),
		.limits      (limits_q),
		.res_valid   (m_tvalid),
		.res_ready   (m_tready),
		.res         (res)
	);

	assign m_tdata = {{(OUT_TDATA_W-OUT_FIELDS_W){1'b0}}, res.pwm_duty, res.next_gain,
		res.auto_mode, res.frame_gain, res.difference_sum, res.signal_sum, res.baseline_sum};

	`PSFA_ASSERT_SAME(a_next_gain_valid, clk, arst_n, m_tvalid,
		res.next_gain != SWITCH_AUTO, "next gain holds the auto switch code")
	`PSFA_ASSERT_SAME(a_duty_zero, clk, arst_n,
		m_tvalid && (res.difference_sum[DIFF_W-1] || res.difference_sum == '0),
		res.pwm_duty == '0, "duty nonzero for a nonpositive difference sum")
	`PSFA_ASSERT_NEXT(a_take_fills, clk, arst_n, frame_take, m_tvalid,
		"frame taken but no result presented")

endmodule

// ===== tb/paired_sample_frame_autorange_tb.sv =====
// testbench for the paired sample frame autorange block: frame predictor, stream drivers, checks
module paired_sample_frame_autorange_tb;
	import psfa_pkg::*;

	localparam int CYCLE_LIMIT      = 200000;
	localparam int PHASES           = 8;
	localparam int FRAMES_PER_PHASE = 7;
	localparam int SETTLE_CYCLES    = 10;
	localparam int MAX_DIFF_SUM     = PAIRS_PER_FRAME * 4095;
	localparam int MAX_PRINTED      = 40;

	// bit offsets of the result fields in m_tdata
	localparam int SIGNAL_LSB = SUM_W;
	localparam int DIFF_LSB   = 2 * SUM_W;
	localparam int GAIN_LSB   = DIFF_LSB + DIFF_W;
	localparam int AUTO_LSB   = GAIN_LSB + GAIN_W;
	localparam int NEXT_LSB   = AUTO_LSB + 1;
	localparam int DUTY_LSB   = NEXT_LSB + GAIN_W;

	class frame_sum_checker;
		logic [LIMIT_W-1:0] raise_limit;
		logic [LIMIT_W-1:0] lower_limit;
		bit                 want_baseline;
		int                 held_baseline;
		int                 pairs_done;
		int                 baseline_acc, signal_acc, difference_acc;
		logic [GAIN_W-1:0]  gain_now;
		result_t            expected_frames[$];
		int                 frames_seen;
		int                 failures;

		function new();
			raise_limit = RAISE_LIMIT_RESET;
			lower_limit = LOWER_LIMIT_RESET;
			want_baseline = 1'b0;
			held_baseline = 0;
			pairs_done = 0;
			baseline_acc = 0;
			signal_acc = 0;
			difference_acc = 0;
			gain_now = GAIN_MED;
			frames_seen = 0;
			failures = 0;
		endfunction

		function void set_limit(logic [CFG_IDX_W-1:0] index, logic [LIMIT_W-1:0] value);
			if (index == CFG_RAISE_LIMIT) raise_limit = value;
			else if (index == CFG_LOWER_LIMIT) lower_limit = value;
		endfunction

		function void note_reading(logic signed [ADC_W-1:0] sample, logic [SWITCH_W-1:0] switches);
			int                level;
			longint            duty;
			logic [GAIN_W-1:0] next_gain;
			result_t           frame;
			if (want_baseline) begin
				held_baseline = sample;
				want_baseline = 1'b0;
				return;
			end
			baseline_acc += held_baseline;
			signal_acc += sample;
			difference_acc += sample - held_baseline;
			want_baseline = 1'b1;
			pairs_done++;
			if (pairs_done < PAIRS_PER_FRAME) return;

			// sums go out unclamped, duty and autorange see the clamped level
			level = difference_acc < 0 ? 0 :
				difference_acc > FULL_SCALE ? FULL_SCALE : difference_acc;
			duty = (longint'(level) * 65535 + FULL_SCALE / 2) / FULL_SCALE;
			if (switches != SWITCH_AUTO) next_gain = switches;
			else if (level > lower_limit) next_gain = (gain_now == GAIN_MAX) ? GAIN_MED : GAIN_MIN;
			else if (level < raise_limit) next_gain = (gain_now == GAIN_MIN) ? GAIN_MED : GAIN_MAX;
			else next_gain = gain_now;

			frame.baseline_sum = SUM_W'(baseline_acc);
			frame.signal_sum = SUM_W'(signal_acc);
			frame.difference_sum = DIFF_W'(difference_acc);
			frame.frame_gain = gain_now;
			frame.auto_mode = (switches == SWITCH_AUTO);
			frame.next_gain = next_gain;
			frame.pwm_duty = DUTY_W'(duty);
			expected_frames.push_back(frame);

			gain_now = next_gain;
			pairs_done = 0;
			baseline_acc = 0;
			signal_acc = 0;
			difference_acc = 0;
		endfunction

		task report(string msg);
			failures++;
			if (failures <= MAX_PRINTED) $display("frame %0d: %s", frames_seen, msg);
		endtask

		task check_frame(logic [OUT_TDATA_W-1:0] tdata);
			result_t want;
			frames_seen++;
			if (expected_frames.size() == 0) begin
				report("output transaction with no frame pending");
				return;
			end
			want = expected_frames.pop_front();
			if (tdata[0 +: SUM_W] !== want.baseline_sum)
				report($sformatf("baseline_sum %0d, expected %0d",
					$signed(tdata[0 +: SUM_W]), want.baseline_sum));
			if (tdata[SIGNAL_LSB +: SUM_W] !== want.signal_sum)
				report($sformatf("signal_sum %0d, expected %0d",
					$signed(tdata[SIGNAL_LSB +: SUM_W]), want.signal_sum));
			if (tdata[DIFF_LSB +: DIFF_W] !== want.difference_sum)
				report($sformatf("difference_sum %0d, expected %0d",
					$signed(tdata[DIFF_LSB +: DIFF_W]), want.difference_sum));
			if (tdata[GAIN_LSB +: GAIN_W] !== want.frame_gain)
				report($sformatf("frame_gain %0d, expected %0d",
					tdata[GAIN_LSB +: GAIN_W], want.frame_gain));
			if (tdata[AUTO_LSB] !== want.auto_mode)
				report($sformatf("auto_mode %0d, expected %0d", tdata[AUTO_LSB], want.auto_mode));
			if (tdata[NEXT_LSB +: GAIN_W] !== want.next_gain)
				report($sformatf("next_gain %0d, expected %0d",
					tdata[NEXT_LSB +: GAIN_W], want.next_gain));
			if (tdata[DUTY_LSB +: DUTY_W] !== want.pwm_duty)
				report($sformatf("pwm_duty %0d, expected %0d",
					tdata[DUTY_LSB +: DUTY_W], want.pwm_duty));
			if (tdata[OUT_TDATA_W-1:OUT_FIELDS_W] !== '0)
				report("padding bits not zero");
		endtask
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   cfg_we;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	frame_sum_checker frames;
	int               send_calm = 0;
	int               sink_calm = 0;
	int               cycle_count = 0;
	int               extreme_readings[8] = '{2047, -2048, 0, -1, 1365, -1366, 1, -2};

	paired_sample_frame_autorange dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// random wait, with runs of back to back transactions now and then
	function automatic int draw_wait(inout int calm_left);
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		if ($urandom_range(0, 9) == 0) begin
			calm_left = $urandom_range(5, 30);
			return 0;
		end
		return $urandom_range(0, 15);
	endfunction

	function automatic int pick_target();
		int t;
		case ($urandom_range(0, 6))
			0: t = int'(frames.raise_limit) + int'($urandom_range(0, 2)) - 1;
			1: t = int'(frames.lower_limit) + int'($urandom_range(0, 2)) - 1;
			2: t = int'($urandom_range(0, 1));
			3: t = FULL_SCALE + int'($urandom_range(0, 2)) - 1;
			4: t = int'($urandom_range(0, 2 * MAX_DIFF_SUM)) - MAX_DIFF_SUM;
			5: t = int'($urandom_range(0, FULL_SCALE));
			default: t = int'(frames.raise_limit) + int'($urandom_range(0, 80)) - 40;
		endcase
		if (t > MAX_DIFF_SUM) t = MAX_DIFF_SUM;
		if (t < -MAX_DIFF_SUM) t = -MAX_DIFF_SUM;
		return t;
	endfunction

	// called and returns at a falling edge
	task automatic send_reading(int sample, logic [SWITCH_W-1:0] switches);
		int gap;
		gap = draw_wait(send_calm);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= IN_TDATA_W'({switches, sample[ADC_W-1:0]});
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		frames.note_reading(sample[ADC_W-1:0], switches);
		@(negedge clk);
	endtask

	task automatic send_frame();
		int                    shape, target, step, rest, d, lo, hi, b;
		logic [SWITCH_W-1:0]   closing_switches;
		shape = $urandom_range(0, 5);
		target = pick_target();
		step = target / PAIRS_PER_FRAME;
		rest = target % PAIRS_PER_FRAME;
		closing_switches = $urandom_range(0, 1) ? SWITCH_AUTO : SWITCH_W'($urandom_range(0, 2));
		for (int k = 0; k < PAIRS_PER_FRAME; k++) begin
			if (shape == 0) begin
				b = int'($urandom_range(0, 4095)) - 2048;
				d = int'($urandom_range(0, 4095)) - 2048 - b;
			end else if (shape == 1) begin
				b = extreme_readings[$urandom_range(0, 7)];
				d = extreme_readings[$urandom_range(0, 7)] - b;
			end else begin
				// spread the target difference sum over the pairs so the frame hits it exactly
				d = step + (k < (rest < 0 ? -rest : rest) ? (rest < 0 ? -1 : 1) : 0);
				lo = d < 0 ? -2048 - d : -2048;
				hi = d > 0 ? 2047 - d : 2047;
				b = lo + int'($urandom_range(0, hi - lo));
			end
			send_reading(b, SWITCH_W'($urandom_range(0, 3)));
			send_reading(b + d, (k == PAIRS_PER_FRAME - 1) ?
				closing_switches : SWITCH_W'($urandom_range(0, 3)));
		end
	endtask

	task automatic write_limits(int raise_value, int lower_value);
		cfg_we <= 1'b1;
		cfg_index <= CFG_RAISE_LIMIT;
		cfg_data <= CFG_DATA_W'(raise_value);
		@(negedge clk);
		cfg_index <= CFG_LOWER_LIMIT;
		cfg_data <= CFG_DATA_W'(lower_value);
		@(negedge clk);
		cfg_we <= 1'b0;
		frames.set_limit(CFG_RAISE_LIMIT, LIMIT_W'(raise_value));
		frames.set_limit(CFG_LOWER_LIMIT, LIMIT_W'(lower_value));
	endtask

	initial begin : result_sink
		int stall;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = draw_wait(sink_calm);
			if (stall > 0) begin
				m_tready <= 1'b0;
				// let the result show first, then hold it back
				@(posedge clk);
				while (!m_tvalid) @(posedge clk);
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			frames.check_frame(m_tdata);
		end
	end

	initial begin : stimulus
		int raise_plan[PHASES];
		int lower_plan[PHASES];
		frames = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_RAISE_LIMIT;
		cfg_data = '0;
		// phase 0 runs on the reset limits, the last one has the band inverted
		raise_plan = '{3840, 0, 65535, 0, 65535, 0, 0, 20000};
		lower_plan = '{26880, 0, 65535, 65535, 0, 0, 0, 1000};
		raise_plan[5] = $urandom_range(0, FULL_SCALE);
		lower_plan[5] = $urandom_range(0, FULL_SCALE);
		raise_plan[6] = $urandom_range(0, 8000);
		lower_plan[6] = $urandom_range(20000, FULL_SCALE);

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// first frame: the opening reading is a signal against a zero baseline
		for (int k = 0; k < 2 * PAIRS_PER_FRAME - 1; k++)
			send_reading(extreme_readings[k % 8],
				(k == 2 * PAIRS_PER_FRAME - 2) ? SWITCH_AUTO : SWITCH_W'(k));

		for (int phase = 0; phase < PHASES; phase++) begin
			if (phase > 0) begin
				s_tvalid <= 1'b0;
				while (frames.expected_frames.size() != 0) @(negedge clk);
				repeat (SETTLE_CYCLES) @(negedge clk);
				write_limits(raise_plan[phase], lower_plan[phase]);
			end
			repeat (FRAMES_PER_PHASE) send_frame();
		end

		s_tvalid <= 1'b0;
		while (frames.expected_frames.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (frames.failures == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
